// ===== sv/ted_pkg.sv =====
// shared types, codes and byte-class helpers for the text encoding detector
package ted_pkg;

	localparam int COUNT_WIDTH_DEF = 24;
	localparam int OUT_WIDTH = 24;
	localparam int WIN_DEPTH = 4;

	localparam logic [1:0] ENC_UTF8 = 2'd0;
	localparam logic [1:0] ENC_SJIS = 2'd1;
	localparam logic [1:0] ENC_EUC  = 2'd2;

	localparam logic [7:0] BOM_B0 = 8'hEF;
	localparam logic [7:0] BOM_B1 = 8'hBB;
	localparam logic [7:0] BOM_B2 = 8'hBF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_DONE
	} ted_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
		logic clear;
	} ted_cmd_t;

	typedef struct packed {
		logic empty;
		logic stall;
	} ted_stat_t;

	function automatic logic [7:0] bom_byte(input logic [1:0] pos);
		logic [7:0] b;
		unique case (pos)
			2'd0: b = BOM_B0;
			2'd1: b = BOM_B1;
			default: b = BOM_B2;
		endcase
		return b;
	endfunction

	function automatic logic is_sj_lead(input logic [7:0] b);
		return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF);
	endfunction

	function automatic logic is_sj_trail(input logic [7:0] b);
		return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
	endfunction

	function automatic logic is_euc_byte(input logic [7:0] b);
		return b >= 8'hA1 && b <= 8'hFE;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

// ===== sv/ted_ctrl.sv =====
// sequencer: load a byte, step the decision unit, emit the verdict on the last byte
module ted_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last,
	input  ted_pkg::ted_stat_t stat,
	output ted_pkg::ted_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import ted_pkg::*;

	ted_state_t state_q, state_d;
	logic       final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start && !busy) begin
				final_q <= last;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.flush = final_q;
		busy      = 1'b1;
		done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_PROC;
				end
			end
			ST_PROC: begin
				if (stat.empty || stat.stall) begin
					state_d = final_q ? ST_DONE : ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				done      = 1'b1;
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_done_after_proc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_PROC))
		else $error("result strobe without a finished flush");

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_accept_goes_proc: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == ST_PROC)
		else $error("accepted item not processed");

	a_stall_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROC && final_q) |-> !stat.stall)
		else $error("flush waiting for lookahead");

endmodule

// ===== sv/ted_dpath.sv =====
// window, decision unit, saturating counters and verdict logic
module ted_dpath #(
	parameter int COUNT_WIDTH = ted_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ted_pkg::ted_cmd_t             cmd,
	input  logic [7:0]                    data_byte,
	output ted_pkg::ted_stat_t            stat,
	output logic [1:0]                    encoding,
	output logic                          bom_seen,
	output logic [ted_pkg::OUT_WIDTH-1:0] shiftjis_score,
	output logic [ted_pkg::OUT_WIDTH-1:0] eucjp_score,
	output logic [ted_pkg::OUT_WIDTH-1:0] utf8_valid_bytes,
	output logic [ted_pkg::OUT_WIDTH-1:0] utf8_invalid_count
);
	import ted_pkg::*;

	localparam int NCNT = 4;
	localparam int C_SJ = 0;
	localparam int C_EUC = 1;
	localparam int C_VAL = 2;
	localparam int C_INV = 3;

	logic [7:0]             win_q [WIN_DEPTH];
	logic [2:0]             fill_q;
	logic [1:0]             pos_q;
	logic                   bom_q;
	logic [COUNT_WIDTH-1:0] cnt_q [NCNT];

	// decision on the oldest window position
	logic       stall;
	logic [2:0] take;
	logic [2:0] inc [NCNT];
	logic       sj, euc, pair_ok;
	logic [2:0] len;
	logic       u8_ok, u8_lead;
	logic [7:0] b0;

	always_comb begin
		b0      = win_q[0];
		sj      = is_sj_lead(b0);
		euc     = is_euc_byte(b0);
		u8_lead = b0 >= 8'hC0 && b0 < 8'hF8;
		len     = (b0 < 8'hE0) ? 3'd2 : (b0 < 8'hF0) ? 3'd3 : 3'd4;
		u8_ok   = fill_q >= len && is_cont(win_q[1])
			&& (len < 3'd3 || is_cont(win_q[2]))
			&& (len < 3'd4 || is_cont(win_q[3]));
		pair_ok = fill_q >= 3'd2;
		stall   = 1'b0;
		take    = 3'd1;
		for (int i = 0; i < NCNT; i++) begin
			inc[i] = 3'd0;
		end
		priority if ((sj || euc) && fill_q < 3'd2 && !cmd.flush) begin
			stall = 1'b1;
			take  = 3'd0;
		end else if (sj && pair_ok && is_sj_trail(win_q[1])) begin
			inc[C_SJ] = 3'd2;
			take      = 3'd2;
		end else if (euc && pair_ok && is_euc_byte(win_q[1])) begin
			inc[C_EUC] = 3'd2;
			take       = 3'd2;
		end else if (u8_lead) begin
			if (fill_q < len && !cmd.flush) begin
				stall = 1'b1;
				take  = 3'd0;
			end else if (u8_ok) begin
				inc[C_VAL] = len;
				take       = len;
			end else begin
				inc[C_INV] = 3'd1;
			end
		end else begin
			take = 3'd1;
		end
	end

	assign stat.empty = fill_q == 3'd0;
	assign stat.stall = stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			bom_q  <= 1'b1;
			for (int i = 0; i < NCNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			fill_q <= '0;
			pos_q  <= '0;
			bom_q  <= 1'b1;
			for (int i = 0; i < NCNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.load) begin
			fill_q <= fill_q + 3'd1;
			if (pos_q != 2'd3) begin
				pos_q <= pos_q + 2'd1;
				if (data_byte != bom_byte(pos_q)) begin
					bom_q <= 1'b0;
				end
			end
		end else if (cmd.step && !stat.empty && !stall) begin
			fill_q <= fill_q - take;
			for (int i = 0; i < NCNT; i++) begin
				logic [COUNT_WIDTH:0] sum;
				sum = {1'b0, cnt_q[i]} + (COUNT_WIDTH + 1)'(inc[i]);
				cnt_q[i] <= sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
			end
		end
	end

	// window payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[fill_q[1:0]] <= data_byte;
		end else if (cmd.step && !stat.empty && !stall) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				logic [2:0] src;
				src = 3'(i) + take;
				if (src < 3'(WIN_DEPTH)) begin
					win_q[i] <= win_q[src[1:0]];
				end
			end
		end
	end

	logic [OUT_WIDTH-1:0] cnt_out [NCNT];

	for (genvar g = 0; g < NCNT; g++) begin : g_sat
		if (COUNT_WIDTH > OUT_WIDTH) begin : g_wide
			assign cnt_out[g] = (|cnt_q[g][COUNT_WIDTH-1:OUT_WIDTH]) ? '1
				: cnt_q[g][OUT_WIDTH-1:0];
		end else begin : g_narrow
			assign cnt_out[g] = OUT_WIDTH'(cnt_q[g]);
		end
	end

	assign shiftjis_score     = cnt_out[C_SJ];
	assign eucjp_score        = cnt_out[C_EUC];
	assign utf8_valid_bytes   = cnt_out[C_VAL];
	assign utf8_invalid_count = cnt_out[C_INV];
	assign bom_seen           = bom_q && pos_q == 2'd3;

	// verdict compares the full-width counters, not the port values
	always_comb begin
		priority if (bom_seen) begin
			encoding = ENC_UTF8;
		end else if (cnt_q[C_INV] == '0 && cnt_q[C_VAL] != '0) begin
			encoding = ENC_UTF8;
		end else if (cnt_q[C_SJ] > cnt_q[C_EUC]) begin
			encoding = ENC_SJIS;
		end else if (cnt_q[C_EUC] != '0) begin
			encoding = ENC_EUC;
		end else begin
			encoding = ENC_UTF8;
		end
	end

	a_room_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> fill_q < 3'(WIN_DEPTH))
		else $error("byte loaded into a full window");

	a_step_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !stat.empty && !stall) |=> fill_q < $past(fill_q))
		else $error("decision step consumed nothing");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> fill_q == 3'd0 && bom_q)
		else $error("state not cleared after result");

endmodule

// ===== sv/text_encoding_detector.sv =====
// top level: classifies a byte stream as UTF-8, Shift-JIS or EUC-JP
// an item is taken in the idle state, then the decision unit resolves the window one
// character (one to four bytes) per step until the window is empty or must wait for more bytes
// on the last byte the window is flushed and the result strobe rises once the flush ends;
// busy stays high while an item is processed, so a new item is taken only after the last is through
// the receiver cannot stall, done lasts exactly one cycle
// arst_n low clears the window fill, bom tracking and all counters
module text_encoding_detector #(
	parameter int COUNT_WIDTH = ted_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [7:0]                    data_byte,
	input  logic                          last,
	output logic                          done,
	output logic [1:0]                    encoding,
	output logic                          bom_seen,
	output logic [ted_pkg::OUT_WIDTH-1:0] shiftjis_score,
	output logic [ted_pkg::OUT_WIDTH-1:0] eucjp_score,
	output logic [ted_pkg::OUT_WIDTH-1:0] utf8_valid_bytes,
	output logic [ted_pkg::OUT_WIDTH-1:0] utf8_invalid_count
);
	import ted_pkg::*;

	ted_cmd_t  cmd;
	ted_stat_t stat;

	ted_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ted_dpath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.data_byte          (data_byte),
		.stat               (stat),
		.encoding           (encoding),
		.bom_seen           (bom_seen),
		.shiftjis_score     (shiftjis_score),
		.eucjp_score        (eucjp_score),
		.utf8_valid_bytes   (utf8_valid_bytes),
		.utf8_invalid_count (utf8_invalid_count)
	);

endmodule
